### hw/rtl/amem_pkg.sv
// ----------------------------------------------------------------------------
// amem_pkg
// Shared types and constants of the accumulator machine execute unit:
// beat structs, opcode codes and multiply/divide command.
// ----------------------------------------------------------------------------
package amem_pkg;

   localparam int MEM_WORDS_DEF = 100;
   localparam int WORD_BITS_DEF = 32;

   localparam int ADDR_W = 7;
   localparam int DATA_W = 32;

   localparam logic [ADDR_W-1:0] PROG_LEN_RST = 7'd100;

   // decimal opcodes
   localparam logic [6:0] OP_LDA  = 7'd11;
   localparam logic [6:0] OP_STA  = 7'd12;
   localparam logic [6:0] OP_ADD  = 7'd21;
   localparam logic [6:0] OP_SUB  = 7'd22;
   localparam logic [6:0] OP_MUL  = 7'd23;
   localparam logic [6:0] OP_DIV  = 7'd24;
   localparam logic [6:0] OP_REM  = 7'd25;
   localparam logic [6:0] OP_REV  = 7'd29;
   localparam logic [6:0] OP_INN  = 7'd31;
   localparam logic [6:0] OP_PRN  = 7'd41;
   localparam logic [6:0] OP_JMP  = 7'd51;
   localparam logic [6:0] OP_JLE  = 7'd52;
   localparam logic [6:0] OP_JDZ  = 7'd53;
   localparam logic [6:0] OP_JGT  = 7'd54;
   localparam logic [6:0] OP_JEQ  = 7'd55;
   localparam logic [6:0] OP_JLT  = 7'd56;
   localparam logic [6:0] OP_JGE  = 7'd57;
   localparam logic [6:0] OP_STOP = 7'd70;

   localparam logic ACT_EXEC  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   typedef struct packed {
      logic                     action;
      logic [6:0]               opcode;
      logic [ADDR_W-1:0]        operand;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]        next_pc;
      logic signed [DATA_W-1:0] acc_value;
      logic                     print_valid;
      logic signed [DATA_W-1:0] print_value;
      logic                     halted;
      logic                     div_error;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic is_mul;
      logic is_rem;
   } md_cmd_type;

endpackage

### hw/rtl/amem_dmem.sv
// ----------------------------------------------------------------------------
// amem_dmem
// Data memory: one write port, one read port with registered read data.
// Per-entry valid bits make unwritten words read as zero after reset.
// ----------------------------------------------------------------------------
module amem_dmem
   import amem_pkg::*;
#(
   parameter int MEM_WORDS = MEM_WORDS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [WORD_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [WORD_BITS-1:0] wr_data
);

   localparam int IDX_W = $clog2(MEM_WORDS);

   logic [WORD_BITS-1:0] mem_ff [MEM_WORDS];
   logic [MEM_WORDS-1:0] valid_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_vld_ff;

   logic             rd_ok, wr_ok;
   logic [IDX_W-1:0] rd_idx, wr_idx;

   // addresses past the end read as zero and drop writes
   assign rd_ok  = {1'b0, rd_addr} < (ADDR_W+1)'(MEM_WORDS);
   assign wr_ok  = wr_en && ({1'b0, wr_addr} < (ADDR_W+1)'(MEM_WORDS));
   assign rd_idx = rd_addr[IDX_W-1:0];
   assign wr_idx = wr_addr[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem_ff[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_ok) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= rd_ok && valid_ff[rd_idx];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

### hw/rtl/amem_muldiv.sv
// ----------------------------------------------------------------------------
// amem_muldiv
// Iterative multiply / signed divide unit, one bit per cycle.
// Multiply is shift-add; divide is restoring on magnitudes with sign fix.
// ----------------------------------------------------------------------------
module amem_muldiv
   import amem_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  md_cmd_type           cmd,
   input  logic [WORD_BITS-1:0] op_a,
   input  logic [WORD_BITS-1:0] op_b,
   output logic                 md_done,
   output logic [WORD_BITS-1:0] md_result
);

   localparam int W     = WORD_BITS;
   localparam int CNT_W = $clog2(WORD_BITS + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             mul_ff, mul_in;
   logic             rem_ff, rem_in;
   logic             negq_ff, negq_in;
   logic             negr_ff, negr_in;
   logic [W-1:0]     x_ff, x_in;
   logic [W-1:0]     y_ff, y_in;
   logic [W-1:0]     z_ff, z_in;
   logic             done_ff, done_in;
   logic [W-1:0]     res_ff, res_in;

   logic [W-1:0] a_mag, b_mag;
   logic [W:0]   trial, diff;
   logic         fits;

   assign a_mag = op_a[W-1] ? ('0 - op_a) : op_a;
   assign b_mag = op_b[W-1] ? ('0 - op_b) : op_b;

   // partial remainder shifted by one dividend bit
   assign trial = {z_ff, x_ff[W-1]};
   assign diff  = trial - {1'b0, y_ff};
   assign fits  = trial >= {1'b0, y_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      mul_in  = mul_ff;
      rem_in  = rem_ff;
      negq_in = negq_ff;
      negr_in = negr_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WORD_BITS);
         mul_in  = cmd.is_mul;
         rem_in  = cmd.is_rem;
         negq_in = op_a[W-1] ^ op_b[W-1];
         negr_in = op_a[W-1];
         z_in    = '0;
         if (cmd.is_mul) begin
            x_in = op_a;
            y_in = op_b;
         end else begin
            x_in = a_mag;
            y_in = b_mag;
         end
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - 1'b1;
            if (mul_ff) begin
               if (y_ff[0]) begin
                  z_in = z_ff + x_ff;
               end
               x_in = x_ff << 1;
               y_in = y_ff >> 1;
            end else begin
               x_in = {x_ff[W-2:0], fits};
               z_in = fits ? diff[W-1:0] : trial[W-1:0];
            end
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (mul_ff) begin
               res_in = z_ff;
            end else if (rem_ff) begin
               res_in = negr_ff ? ('0 - z_ff) : z_ff;
            end else begin
               res_in = negq_ff ? ('0 - x_ff) : x_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      mul_ff  <= mul_in;
      rem_ff  <= rem_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      res_ff  <= res_in;
   end

   assign md_done   = done_ff;
   assign md_result = res_ff;

endmodule

### hw/rtl/accumulator_machine_execute.sv
// ----------------------------------------------------------------------------
// accumulator_machine_execute
// Execute unit of a decimal-opcode accumulator machine: accumulator,
// program counter, stop flag and a data memory, one beat in, one beat out.
//
//   port group   dir   handshake           payload
//   req_*        in    req_valid/stall     req_beat   (req_type)
//   rsp_*        out   rsp_valid/stall     rsp_beat   (rsp_type)
//   csr_*        in    csr_wr_en           csr_wr_data (program length)
//
// A beat passes through accept, memory read, execute with write-back and
// response load; MUL, and DIV or REM by a nonzero divisor, use the bit-serial
// unit. The memory port is the single access point per beat. Synchronous
// reset clears state, acc, pc, stop, response valid and memory valid bits
// at once; no clearing pass. A new beat is accepted while the last response
// waits under rsp_stall; the response load then waits for the output register.
// ----------------------------------------------------------------------------
module accumulator_machine_execute
   import amem_pkg::*;
#(
   parameter int MEM_WORDS = MEM_WORDS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_beat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_beat,
   input  logic              csr_wr_en,
   input  logic [ADDR_W-1:0] csr_wr_data
);

   localparam int W = WORD_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_MULDIV,
      S_RESP
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]      acc_ff, acc_in;
   logic [ADDR_W-1:0] pc_ff, pc_in;
   logic              stopped_ff, stopped_in;
   logic [ADDR_W-1:0] prog_len_ff;
   logic              pvalid_ff, pvalid_in;
   logic [DATA_W-1:0] pval_ff, pval_in;
   logic              derr_ff, derr_in;

   logic              mem_rd_en, mem_wr_en;
   logic [W-1:0]      mem_rd_data, mem_wr_data;
   md_cmd_type        md_cmd;
   logic              md_done;
   logic [W-1:0]      md_result;

   logic signed [63:0] val_sx;
   logic [W-1:0]       val_w;
   logic [63:0]        acc_zx, m_zx;
   logic               active, acc_neg, acc_zero, jump, rsp_free;
   logic [ADDR_W-1:0]  npc;

   amem_dmem #(
      .MEM_WORDS (MEM_WORDS),
      .WORD_BITS (WORD_BITS)
   ) u_dmem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (req_ff.operand),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (req_ff.operand),
      .wr_data (mem_wr_data)
   );

   amem_muldiv #(
      .WORD_BITS (WORD_BITS)
   ) u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .cmd       (md_cmd),
      .op_a      (acc_ff),
      .op_b      (mem_rd_data),
      .md_done   (md_done),
      .md_result (md_result)
   );

   // input word is sign-extended, stored words leave zero-extended
   assign val_sx   = 64'(req_ff.value);
   assign val_w    = W'(val_sx);
   assign acc_zx   = 64'(acc_ff);
   assign m_zx     = 64'(mem_rd_data);
   assign active   = !stopped_ff && (pc_ff < prog_len_ff);
   assign acc_neg  = acc_ff[W-1];
   assign acc_zero = acc_ff == '0;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      acc_in       = acc_ff;
      pc_in        = pc_ff;
      stopped_in   = stopped_ff;
      pvalid_in    = pvalid_ff;
      pval_in      = pval_ff;
      derr_in      = derr_ff;
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_data  = val_w;
      md_cmd       = '0;
      jump         = 1'b0;
      npc          = pc_ff + 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_beat;
               state_in = S_READ;
            end
         end
         S_READ: begin
            mem_rd_en = 1'b1;
            pvalid_in = 1'b0;
            pval_in   = '0;
            derr_in   = 1'b0;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
            if (req_ff.action == ACT_WRITE) begin
               mem_wr_en = 1'b1;
            end else if (active) begin
               unique case (req_ff.opcode) inside
                  OP_LDA: acc_in = mem_rd_data;
                  OP_STA: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = acc_ff;
                  end
                  OP_ADD: acc_in = acc_ff + mem_rd_data;
                  OP_SUB: acc_in = acc_ff - mem_rd_data;
                  OP_MUL: begin
                     md_cmd.start  = 1'b1;
                     md_cmd.is_mul = 1'b1;
                     state_in      = S_MULDIV;
                  end
                  OP_DIV, OP_REM: begin
                     if (mem_rd_data == '0) begin
                        derr_in = 1'b1;
                     end else begin
                        md_cmd.start  = 1'b1;
                        md_cmd.is_rem = req_ff.opcode == OP_REM;
                        state_in      = S_MULDIV;
                     end
                  end
                  OP_REV: acc_in = '0 - acc_ff;
                  OP_INN: mem_wr_en = 1'b1;
                  OP_PRN: begin
                     pvalid_in = 1'b1;
                     pval_in   = m_zx[DATA_W-1:0];
                  end
                  OP_JMP: jump = 1'b1;
                  OP_JLE: jump = acc_neg || acc_zero;
                  OP_JDZ: jump = !acc_zero;
                  OP_JGT: jump = !acc_neg && !acc_zero;
                  OP_JEQ: jump = acc_zero;
                  OP_JLT: jump = acc_neg;
                  OP_JGE: jump = !acc_neg;
                  OP_STOP: begin
                     stopped_in = 1'b1;
                     npc        = pc_ff;
                  end
                  default: ;
               endcase
               pc_in = jump ? req_ff.operand : npc;
            end
         end
         S_MULDIV: begin
            if (md_done) begin
               acc_in   = md_result;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_in.next_pc     = pc_ff;
               rsp_in.acc_value   = acc_zx[DATA_W-1:0];
               rsp_in.print_valid = pvalid_ff;
               rsp_in.print_value = pval_ff;
               rsp_in.halted      = stopped_ff || (pc_ff >= prog_len_ff);
               rsp_in.div_error   = derr_ff;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         pc_ff        <= '0;
         stopped_ff   <= 1'b0;
         prog_len_ff  <= PROG_LEN_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         pc_ff        <= pc_in;
         stopped_ff   <= stopped_in;
         if (csr_wr_en) begin
            prog_len_ff <= csr_wr_data;
         end
      end
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      pvalid_ff <= pvalid_in;
      pval_ff   <= pval_in;
      derr_ff   <= derr_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   // a response only appears out of the response state
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_RESP)
      else $error("response beat raised outside response state");

   // the arithmetic unit only finishes while the sequencer waits for it
   a_md_done_wait: assert property (@(posedge clock) disable iff (reset)
      md_done |-> state_ff == S_MULDIV)
      else $error("multiply/divide result arrived while not waiting");

   // once stopped the program counter holds until reset
   a_stop_holds_pc: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> (pc_ff == $past(pc_ff)) && stopped_ff)
      else $error("program counter moved after stop");

endmodule

### sim/tb_accumulator_machine_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accumulator_machine_execute
// Self-checking bench for the accumulator machine execute unit. A shadow
// copy of the accumulator, program counter, stop flag and data memory
// predicts every response beat. Directed tests cover data words at the
// extremes, every opcode, zero divisors, out-of-range addresses, program
// length changes and STOP. Random instruction streams then run under
// several program lengths. The sender moves in bursts with gaps and the
// receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_accumulator_machine_execute;
   import amem_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 48;
   localparam int RANDOM_ITEMS  = 225;
   localparam int REPORT_MAX    = 10;

   localparam logic [6:0] OP_NOP = 7'd50;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_beat = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_beat;
   logic              csr_wr_en = 1'b0;
   logic [ADDR_W-1:0] csr_wr_data = '0;

   // shadow machine state
   logic [31:0] shadow_acc;
   logic [6:0]  shadow_pc;
   logic [31:0] shadow_words [0:MEM_WORDS_DEF-1];
   logic        shadow_stop;
   logic [6:0]  shadow_len;

   rsp_type step_results_q[$];
   int      fail_count = 0;
   int      cycle_count = 0;
   int      burst_left = 0;
   int      stall_mode = 0;
   int      stall_left = 0;

   accumulator_machine_execute uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_beat   (req_beat),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_beat   (rsp_beat),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // one instruction or memory write applied to the shadow state
   function automatic rsp_type machine_step(input req_type b);
      rsp_type     r;
      logic [31:0] m;
      logic [31:0] a;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [6:0]  npc;
      logic        neg;
      logic        zero;
      logic        jump;
      r = '0;
      if (b.action == ACT_WRITE) begin
         if (b.operand < MEM_WORDS_DEF) shadow_words[b.operand] = b.value;
      end else if (!shadow_stop && shadow_pc < shadow_len) begin
         m = (b.operand < MEM_WORDS_DEF) ? shadow_words[b.operand] : 32'd0;
         a = shadow_acc;
         neg = a[31];
         zero = (a == 32'd0);
         jump = 1'b0;
         npc = shadow_pc + 7'd1;
         case (b.opcode) inside
            OP_LDA: a = m;
            OP_STA: begin
               if (b.operand < MEM_WORDS_DEF) shadow_words[b.operand] = a;
            end
            OP_ADD: a = a + m;
            OP_SUB: a = a - m;
            OP_MUL: a = a * m;
            OP_DIV, OP_REM: begin
               if (m == 32'd0) begin
                  r.div_error = 1'b1;
               end else begin
                  ma = neg ? -a : a;
                  mb = m[31] ? -m : m;
                  if (b.opcode == OP_DIV) begin
                     a = (neg != m[31]) ? -(ma / mb) : (ma / mb);
                  end else begin
                     a = neg ? -(ma % mb) : (ma % mb);
                  end
               end
            end
            OP_REV: a = -a;
            OP_INN: begin
               if (b.operand < MEM_WORDS_DEF) shadow_words[b.operand] = b.value;
            end
            OP_PRN: begin
               r.print_valid = 1'b1;
               r.print_value = m;
            end
            OP_JMP: jump = 1'b1;
            OP_JLE: jump = neg || zero;
            OP_JDZ: jump = !zero;
            OP_JGT: jump = !neg && !zero;
            OP_JEQ: jump = zero;
            OP_JLT: jump = neg;
            OP_JGE: jump = !neg;
            OP_STOP: begin
               shadow_stop = 1'b1;
               npc = shadow_pc;
            end
            default: ;
         endcase
         if (jump) npc = b.operand;
         shadow_acc = a;
         shadow_pc = npc;
      end
      r.next_pc = shadow_pc;
      r.acc_value = shadow_acc;
      r.halted = shadow_stop || (shadow_pc >= shadow_len);
      return r;
   endfunction

   task automatic send_beat(input req_type b);
      int gap;
      req_beat <= b;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      step_results_q.push_back(machine_step(b));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 11);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic run_op(input logic [6:0] op, input logic [6:0] arg,
                         input logic [31:0] word);
      req_type b;
      b.action = ACT_EXEC;
      b.opcode = op;
      b.operand = arg;
      b.value = word;
      send_beat(b);
   endtask

   task automatic poke_word(input logic [6:0] addr, input logic [31:0] word);
      req_type b;
      b.action = ACT_WRITE;
      b.opcode = 7'($urandom_range(0, 127));
      b.operand = addr;
      b.value = word;
      send_beat(b);
   endtask

   // sender holds off until every response is back
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (step_results_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_program_length(input logic [6:0] len);
      wait_results_drained();
      csr_wr_data <= len;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      shadow_len = len;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'hFFFF_FFFF;
         4, 5: return $urandom_range(0, 40) - 20;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [6:0] rand_addr();
      int k;
      k = $urandom_range(0, 9);
      if (k < 5) return 7'($urandom_range(0, 15));
      else if (k < 9) return 7'($urandom_range(0, 99));
      else return 7'($urandom_range(100, 127));
   endfunction

   function automatic logic [6:0] pick_opcode();
      logic [6:0] op;
      case ($urandom_range(0, 19))
         0, 1: op = OP_LDA;
         2: op = OP_STA;
         3: op = OP_ADD;
         4: op = OP_SUB;
         5: op = OP_MUL;
         6: op = OP_DIV;
         7: op = OP_REM;
         8: op = OP_REV;
         9: op = OP_INN;
         10: op = OP_PRN;
         11: op = OP_NOP;
         12: op = OP_JMP;
         13: op = OP_JLE;
         14: op = OP_JDZ;
         15: op = OP_JGT;
         16: op = OP_JEQ;
         17: op = OP_JLT;
         18: op = OP_JGE;
         default: begin
            op = 7'($urandom_range(0, 127));
            // stop only at the very end, it cannot be undone
            if (op == OP_STOP) op = OP_NOP;
         end
      endcase
      return op;
   endfunction

   // keeps the program counter inside the program so the stream stays live
   function automatic req_type rand_instr();
      req_type b;
      b.value = rand_word();
      b.operand = rand_addr();
      if ($urandom_range(0, 99) < 15) begin
         b.action = ACT_WRITE;
         b.opcode = 7'($urandom_range(0, 127));
      end else begin
         b.action = ACT_EXEC;
         if (int'(shadow_pc) + 1 >= int'(shadow_len)) b.opcode = OP_JMP;
         else b.opcode = pick_opcode();
         if (b.opcode >= OP_JMP && b.opcode <= OP_JGE)
            b.operand = 7'($urandom_range(0, int'(shadow_len) - 1));
      end
      return b;
   endfunction

   task automatic do_reset();
      shadow_acc = '0;
      shadow_pc = '0;
      shadow_stop = 1'b0;
      shadow_len = PROG_LEN_RST;
      for (int i = 0; i < MEM_WORDS_DEF; i++) shadow_words[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_data_and_arith();
      poke_word(7'd0, 32'h7FFF_FFFF);
      poke_word(7'd1, 32'h8000_0000);
      poke_word(7'd2, 32'hFFFF_FFFF);
      poke_word(7'd127, 32'h1234_5678);
      run_op(OP_LDA, 7'd1, 32'd0);
      // most negative over -1 wraps, remainder is zero
      run_op(OP_DIV, 7'd2, 32'd0);
      run_op(OP_REM, 7'd2, 32'd0);
      run_op(OP_ADD, 7'd0, 32'd0);
      run_op(OP_ADD, 7'd0, 32'd0);
      run_op(OP_SUB, 7'd1, 32'd0);
      run_op(OP_MUL, 7'd2, 32'd0);
      run_op(OP_DIV, 7'd99, 32'd0);
      run_op(OP_REM, 7'd99, 32'd0);
      run_op(OP_REV, 7'd0, 32'd0);
      run_op(OP_INN, 7'd3, -32'sd5);
      run_op(OP_REM, 7'd3, 32'd0);
      run_op(OP_PRN, 7'd3, 32'd0);
      run_op(OP_PRN, 7'd120, 32'd0);
      run_op(OP_STA, 7'd127, 32'd0);
      run_op(7'd0, 7'd4, 32'hFFFF_FFFF);
      run_op(OP_NOP, 7'd5, 32'd0);
      run_op(7'd127, 7'd127, 32'd0);
   endtask

   task automatic test_jumps();
      run_op(OP_LDA, 7'd127, 32'd0);
      run_op(OP_JEQ, 7'd20, 32'd0);
      run_op(OP_JDZ, 7'd40, 32'd0);
      run_op(OP_JGT, 7'd40, 32'd0);
      run_op(OP_JLE, 7'd30, 32'd0);
      run_op(OP_JGE, 7'd35, 32'd0);
      run_op(OP_LDA, 7'd1, 32'd0);
      run_op(OP_JLT, 7'd60, 32'd0);
      run_op(OP_JGE, 7'd70, 32'd0);
      run_op(OP_JMP, 7'd5, 32'd0);
   endtask

   task automatic test_program_length();
      run_op(OP_JMP, 7'd0, 32'd0);
      set_program_length(7'd1);
      run_op(OP_NOP, 7'd0, 32'd0);
      // past the end: nothing moves
      run_op(OP_ADD, 7'd0, 32'd0);
      set_program_length(7'd40);
      run_op(OP_JMP, 7'd50, 32'd0);
      poke_word(7'd5, 32'h0BAD_F00D);
      run_op(OP_PRN, 7'd5, 32'd0);
      set_program_length(7'd100);
      run_op(OP_PRN, 7'd5, 32'd0);
   endtask

   task automatic test_random_streams();
      logic [6:0] lens [0:3];
      lens[0] = 7'd100;
      lens[1] = 7'($urandom_range(2, 10));
      lens[2] = 7'($urandom_range(11, 99));
      lens[3] = 7'd100;
      for (int p = 0; p < 4; p++) begin
         run_op(OP_JMP, 7'd0, 32'd0);
         set_program_length(lens[p]);
         for (int i = 0; i < RANDOM_ITEMS; i++) send_beat(rand_instr());
      end
   endtask

   task automatic test_stop();
      run_op(OP_STOP, 7'd0, 32'd0);
      run_op(OP_ADD, 7'd0, 32'd0);
      run_op(OP_PRN, 7'd0, 32'd0);
      poke_word(7'd7, 32'h5555_AAAA);
      run_op(OP_LDA, 7'd7, 32'd0);
      run_op(OP_JMP, 7'd0, 32'd0);
      wait_results_drained();
   endtask

   initial begin
      do_reset();
      test_data_and_arith();
      test_jumps();
      test_program_length();
      test_random_streams();
      test_stop();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[accumulator_machine_execute] OK");
      end else begin
         $display("[accumulator_machine_execute] ERROR");
      end
      $finish;
   end

   // receiver back-pressure, changes character every so often
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ((stall_left % 16) < 10);
      endcase
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (step_results_q.size() == 0) begin
            if (fail_count < REPORT_MAX)
               $display("unexpected response beat %h", rsp_beat);
            fail_count++;
         end else begin
            want = step_results_q.pop_front();
            if (rsp_beat.next_pc !== want.next_pc ||
                rsp_beat.acc_value !== want.acc_value ||
                rsp_beat.print_valid !== want.print_valid ||
                rsp_beat.print_value !== want.print_value ||
                rsp_beat.halted !== want.halted ||
                rsp_beat.div_error !== want.div_error) begin
               if (fail_count < REPORT_MAX) begin
                  $display("mismatch exp/got: pc %0d/%0d acc %h/%h prn %b %h/%b %h",
                           want.next_pc, rsp_beat.next_pc,
                           want.acc_value, rsp_beat.acc_value,
                           want.print_valid, want.print_value,
                           rsp_beat.print_valid, rsp_beat.print_value);
                  $display("   halted %b/%b div_error %b/%b",
                           want.halted, rsp_beat.halted,
                           want.div_error, rsp_beat.div_error);
               end
               fail_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[accumulator_machine_execute] ERROR");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/amem_pkg.sv
hw/rtl/amem_dmem.sv
hw/rtl/amem_muldiv.sv
hw/rtl/accumulator_machine_execute.sv
sim/tb_accumulator_machine_execute.sv
